// File: rtl/els_pkg.sv
// types, codes and reset values shared by the encoder link supervisor
`timescale 1ns / 1ps
package els_pkg;

   localparam logic [2:0] CMD_READ_DONE  = 3'd0;
   localparam logic [2:0] CMD_BUS_ERROR  = 3'd1;
   localparam logic [2:0] CMD_START_FAIL = 3'd2;
   localparam logic [2:0] CMD_HOUSEKEEP  = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   localparam logic [1:0] REG_STALE_TIMEOUT   = 2'd0;
   localparam logic [1:0] REG_STARTUP_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd2;

   localparam logic [15:0] STALE_TIMEOUT_RESET   = 16'd20;
   localparam logic [15:0] STARTUP_TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] RETRY_INTERVAL_RESET  = 16'd20;

   localparam logic [3:0] ANGLE_HIGH_MASK = 4'hF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic [7:0]  rx_high;
      logic [7:0]  rx_low;
      logic [31:0] max_age;
   } els_req_type;

   typedef struct packed {
      logic [11:0] angle_out;
      logic        link_ok;
      logic        fresh;
      logic        issue_read;
      logic        reinit_bus;
   } els_rsp_type;

   typedef struct packed {
      logic [11:0] angle_reg;
      logic        have_sample;
      logic        recovery_pending;
      logic        error_flag;
      logic [31:0] last_update_time;
      logic [31:0] last_attempt_time;
   } els_state_type;

   typedef struct packed {
      logic [15:0] stale_timeout_ms;
      logic [15:0] startup_timeout_ms;
      logic [15:0] retry_interval_ms;
   } els_cfg_type;

endpackage

// File: rtl/encoder_link_supervisor_top.sv
// encoder link supervisor: request register, state, evaluation and response register
`timescale 1ns / 1ps
// Supervises the link to a magnetic angle sensor, one event per request.
// Request channel (req_valid / req_stall / req_data) carries cmd, timestamp,
// the two received bytes and a freshness limit. Response channel
// (rsp_valid / rsp_stall / rsp_data) returns the held angle, link status,
// freshness answer and read / bus reinit requests, one response per request
// in order.
// Configuration (csr_valid / csr_ready / csr_index / csr_data) sets the stale
// timeout, startup timeout and retry interval; csr_ready is always high and
// writes to unused indexes are dropped. Write only while the block is idle.
// A request taken into the request register passes through the evaluation stage
// into the response register, and waits while the response register is stalled.
// Throughput: one request per cycle while the receiver does not stall, with the
// single evaluation stage between the registers.
// Reset (synchronous, active high) empties both registers, loads the
// configuration defaults and sets the link to faulted with no sample.
// When the receiver stalls, the response holds and the request register
// holds too, so req_stall rises once both stages are full.
module encoder_link_supervisor_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  els_pkg::els_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output els_pkg::els_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data
);
   import els_pkg::*;

   els_req_type   req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   els_rsp_type   rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   els_state_type state_ff;
   els_state_type state_in;
   els_cfg_type   cfg_ff;
   els_rsp_type   rsp_in;
   logic          advance;
   logic          req_take;

   // the evaluation stage moves when the response register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   els_eval u_eval (
      .req        (req_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff               <= 1'b0;
         rsp_valid_ff               <= 1'b0;
         state_ff.angle_reg         <= '0;
         state_ff.have_sample       <= 1'b0;
         state_ff.recovery_pending  <= 1'b0;
         state_ff.error_flag        <= 1'b1;
         state_ff.last_update_time  <= '0;
         state_ff.last_attempt_time <= '0;
         cfg_ff.stale_timeout_ms    <= STALE_TIMEOUT_RESET;
         cfg_ff.startup_timeout_ms  <= STARTUP_TIMEOUT_RESET;
         cfg_ff.retry_interval_ms   <= RETRY_INTERVAL_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STALE_TIMEOUT:   cfg_ff.stale_timeout_ms   <= csr_data;
               REG_STARTUP_TIMEOUT: cfg_ff.startup_timeout_ms <= csr_data;
               REG_RETRY_INTERVAL:  cfg_ff.retry_interval_ms  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a bus reinit always comes with a read
   a_reinit_reads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reinit_bus |-> rsp_data.issue_read)
      else $error("reinit without read request");

   // a retry leaves the fault standing until a read completes
   a_reinit_faulted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reinit_bus |-> !rsp_data.link_ok)
      else $error("reinit on a healthy link");

   a_fresh_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fresh |-> rsp_data.link_ok)
      else $error("fresh answer on a faulted link");

   // a held request with an empty response register must move on
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("request lost between stages");

endmodule

// File: rtl/els_eval.sv
// event evaluation: next supervisor state and the response for one request
`timescale 1ns / 1ps
module els_eval (
   input  els_pkg::els_req_type   req,
   input  els_pkg::els_state_type state,
   input  els_pkg::els_cfg_type   cfg,
   output els_pkg::els_state_type state_next,
   output els_pkg::els_rsp_type   rsp
);
   import els_pkg::*;

   logic [31:0] update_age;
   logic [31:0] attempt_age;
   logic        stuck;
   logic        never;
   logic        pending;
   logic        fresh;
   logic        issue;
   logic        reinit;

   assign update_age  = req.now_ms - state.last_update_time;
   assign attempt_age = req.now_ms - state.last_attempt_time;
   assign stuck = state.have_sample && (update_age > {16'd0, cfg.stale_timeout_ms});
   assign never = !state.have_sample && (req.now_ms > {16'd0, cfg.startup_timeout_ms});

   always_comb begin
      state_next = state;
      fresh      = 1'b0;
      issue      = 1'b0;
      reinit     = 1'b0;
      pending    = state.recovery_pending;
      case (req.cmd)
         CMD_READ_DONE: begin
            state_next.angle_reg        = {req.rx_high[3:0] & ANGLE_HIGH_MASK, req.rx_low};
            state_next.last_update_time = req.now_ms;
            state_next.have_sample      = 1'b1;
            state_next.recovery_pending = 1'b0;
            state_next.error_flag       = 1'b0;
            issue                       = 1'b1;
         end
         CMD_BUS_ERROR, CMD_START_FAIL: begin
            state_next.error_flag       = 1'b1;
            state_next.recovery_pending = 1'b1;
         end
         CMD_HOUSEKEEP: begin
            // a queued recovery suppresses new fault detection
            if (!pending && (stuck || never)) begin
               state_next.error_flag = 1'b1;
               pending               = 1'b1;
            end
            state_next.recovery_pending = pending;
            if (pending && (attempt_age >= {16'd0, cfg.retry_interval_ms})) begin
               state_next.last_attempt_time = req.now_ms;
               state_next.recovery_pending  = 1'b0;
               reinit                       = 1'b1;
               issue                        = 1'b1;
            end
         end
         CMD_QUERY: begin
            fresh = state.have_sample && !state.error_flag && (update_age <= req.max_age);
         end
         default: begin
         end
      endcase
   end

   assign rsp.angle_out  = state_next.angle_reg;
   assign rsp.link_ok    = !state_next.error_flag;
   assign rsp.fresh      = fresh;
   assign rsp.issue_read = issue;
   assign rsp.reinit_bus = reinit;

endmodule
